// ===== rtl/core/qfts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfts_pkg
// Shared types and constants for the two-stack queue.
// ----------------------------------------------------------------------------
package qfts_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned DataWidthDef  = 32;
  localparam int unsigned PortWidth     = 32;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controls one stack for one cycle. Push and pop are never both set.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  // Occupancy flags of one stack.
  typedef struct packed {
    logic empty;
    logic full;
    logic one_left;
  } stk_stat_t;

endpackage

// ===== rtl/core/qfts_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfts_cell
// One word of a shifting stack: takes the word above on push, below on pop.
// ----------------------------------------------------------------------------
module qfts_cell import qfts_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                  clk_i,
  input  stk_ctrl_t             ctrl_i,
  input  logic [DATA_WIDTH-1:0] above_i,
  input  logic [DATA_WIDTH-1:0] below_i,
  output logic [DATA_WIDTH-1:0] word_o
);

  logic [DATA_WIDTH-1:0] word_q;
  logic [DATA_WIDTH-1:0] word_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.push) begin
      word_d = above_i;
    end else if (ctrl_i.pop) begin
      word_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== rtl/core/qfts_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfts_stack
// Bounded stack as a chain of cells; the top of stack always sits in cell 0.
// ----------------------------------------------------------------------------
module qfts_stack import qfts_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDef,
  parameter int unsigned DATA_WIDTH  = DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stk_ctrl_t             ctrl_i,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  output logic [DATA_WIDTH-1:0] top_o,
  output stk_stat_t             stat_o
);

  localparam int unsigned CntWidth = $clog2(STACK_DEPTH + 1);

  logic [DATA_WIDTH-1:0] words [STACK_DEPTH];
  logic [CntWidth-1:0]   cnt_q;
  logic [CntWidth-1:0]   cnt_d;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] above;
    logic [DATA_WIDTH-1:0] below;
    if (i == 0) begin : g_first
      assign above = push_data_i;
    end else begin : g_mid
      assign above = words[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = words[i];
    end else begin : g_inner
      assign below = words[i+1];
    end
    qfts_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .above_i(above),
      .below_i(below),
      .word_o (words[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.push) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (ctrl_i.pop) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign top_o           = words[0];
  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.full     = (cnt_q == CntWidth'(STACK_DEPTH));
  assign stat_o.one_left = (cnt_q == CntWidth'(1));

endmodule

// ===== rtl/core/queue_from_two_stacks.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_from_two_stacks
// FIFO queue built from an inbox and an outbox stack of shifting cells.
// An accepted request enters S_EXEC, which registers the result when no stack
// move is needed and the output is free. A move passes through S_XFER, which
// shifts every inbox word, at most STACK_DEPTH, onto the outbox one word per
// cycle through the cell chains; one transaction at a time in the sequencer.
// Reset clears both stack counts and the sequencer; cell contents are not reset.
// ----------------------------------------------------------------------------
module queue_from_two_stacks import qfts_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDef,
  parameter int unsigned DATA_WIDTH  = DataWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic signed [PortWidth-1:0] data_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic signed [PortWidth-1:0] data_out_o,
  output logic                        queue_empty_o
);

  localparam int unsigned ExtWidth = DATA_WIDTH + PortWidth;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_XFER
  } state_e;

  state_e                state_q, state_d;
  logic                  deq_q;
  logic [DATA_WIDTH-1:0] word_q;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  qempty_q, qempty_d;

  stk_ctrl_t             ib_ctrl, ob_ctrl;
  stk_stat_t             ib_stat, ob_stat;
  logic [DATA_WIDTH-1:0] ib_top, ob_top;
  logic                  in_acc, out_free, need_xfer;
  logic [ExtWidth-1:0]   in_ext, out_ext;

  assign in_ext = {{DATA_WIDTH{1'b0}}, data_in_i};
  assign out_ext = {{PortWidth{1'b0}}, data_q};

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign need_xfer  = deq_q ? (ob_stat.empty && !ib_stat.empty)
                            : (ib_stat.full && ob_stat.empty);

  qfts_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_inbox (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ib_ctrl),
    .push_data_i(word_q),
    .top_o      (ib_top),
    .stat_o     (ib_stat)
  );

  qfts_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_outbox (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ob_ctrl),
    .push_data_i(ib_top),
    .top_o      (ob_top),
    .stat_o     (ob_stat)
  );

  always_comb begin
    state_d     = state_q;
    ib_ctrl     = '0;
    ob_ctrl     = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    data_d      = data_q;
    qempty_d    = qempty_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (need_xfer) begin
          state_d = S_XFER;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          data_d      = '0;
          state_d     = S_IDLE;
          if (!deq_q) begin
            qempty_d = 1'b0;
            if (ib_stat.full) begin
              status_d = ST_FULL;
            end else begin
              status_d     = ST_DONE;
              ib_ctrl.push = 1'b1;
            end
          end else if (ob_stat.empty) begin
            status_d = ST_EMPTY;
            qempty_d = 1'b1;
          end else begin
            status_d    = ST_DONE;
            ob_ctrl.pop = 1'b1;
            data_d      = ob_top;
            qempty_d    = ib_stat.empty && ob_stat.one_left;
          end
        end
      end
      S_XFER: begin
        // move one word per cycle, reversing order onto the outbox
        if (ib_stat.empty) begin
          state_d = S_EXEC;
        end else begin
          ib_ctrl.pop  = 1'b1;
          ob_ctrl.push = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= ST_DONE;
      qempty_q    <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      qempty_q    <= qempty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      deq_q  <= action_i;
      word_q <= in_ext[DATA_WIDTH-1:0];
    end
    data_q <= data_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_out_o    = out_ext[PortWidth-1:0];
  assign queue_empty_o = qempty_q;

endmodule

// ===== rtl/core/qfts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfts_checker
// Port-level checks on the two-stack queue, bound to the top level.
// ----------------------------------------------------------------------------
module qfts_checker import qfts_pkg::*; (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  status_o,
  input logic signed [PortWidth-1:0] data_out_o,
  input logic                        queue_empty_o
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(data_out_o) && $stable(queue_empty_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_DONE || status_o == ST_FULL
      || status_o == ST_EMPTY))
    else $error("undefined status code");

  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_DONE) |-> (data_out_o == '0))
    else $error("nonzero data on a failed transaction");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> queue_empty_o)
    else $error("empty dequeue but queue not empty");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> !queue_empty_o)
    else $error("full rejection but queue reported empty");

endmodule

bind queue_from_two_stacks qfts_checker u_qfts_checker (.*);
